// ===== design/tksrq_pkg.sv =====
// ----------------------------------------------------------------------------
// tksrq_pkg: shared types and codes of the two-key sorted ring queue
// Transaction payloads, entry layout, operation and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tksrq_pkg;

  // widths fixed by the transaction fields
  localparam int KEY_W  = 8;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;
  localparam int RING_W = 5;
  localparam int CNT_W  = 5;

  // ring size after reset
  localparam int RING_RESET = 16;

  // operation codes
  localparam logic [OP_W-1:0] OP_ENQ    = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESORT = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] item_id;
    logic [KEY_W-1:0] patience;
    logic [KEY_W-1:0] priority_req;
  } req_item_t;

  typedef struct packed {
    logic             item_valid;
    logic [KEY_W-1:0] out_id;
    logic [KEY_W-1:0] out_patience;
    logic [KEY_W-1:0] out_priority;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] count;
  } rsp_item_t;

  // one ring slot
  typedef struct packed {
    logic [KEY_W-1:0] id;
    logic [KEY_W-1:0] patience;
    logic [KEY_W-1:0] prio;
  } entry_t;

endpackage

`default_nettype wire

// ===== design/tksrq_req_if.sv =====
// ----------------------------------------------------------------------------
// tksrq_req_if: request channel of the sorted ring queue
// Valid/ready channel carrying one operation per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface tksrq_req_if;
  import tksrq_pkg::*;

  logic      valid;
  logic      ready;
  req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/tksrq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tksrq_rsp_if: response channel of the sorted ring queue
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface tksrq_rsp_if;
  import tksrq_pkg::*;

  logic      valid;
  logic      ready;
  rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/tksrq_engine.sv =====
// ----------------------------------------------------------------------------
// tksrq_engine: slot memory and sequencer of the sorted ring queue
// Holds the ring in a synchronous RAM and runs enqueue, dequeue, id search
// and the bubbling toward the head on both keys as read-modify-write steps, one swap a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tksrq_engine #(
  parameter int CAPACITY = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cmd_valid,
  output logic                             cmd_ready,
  input  wire tksrq_pkg::req_item_t        cmd,
  input  wire logic [tksrq_pkg::RING_W-1:0] ring,
  input  wire logic                        clear,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output tksrq_pkg::rsp_item_t             res
);
  import tksrq_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int XW = ((IW > RING_W) ? IW : RING_W) + 1;

  typedef logic [IW-1:0] idx_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DEQ, S_SRCH, S_START, S_BUB, S_FIN, S_PUT
  } state_t;

  // next slot index, wrapping at the ring size
  function automatic idx_t idx_inc(idx_t x, logic [RING_W-1:0] m);
    logic [XW-1:0] s;
    s = XW'(x) + XW'(1);
    return (s == XW'(m)) ? '0 : s[IW-1:0];
  endfunction

  // previous slot index, wrapping at the ring size
  function automatic idx_t idx_dec(idx_t x, logic [RING_W-1:0] m);
    logic [XW-1:0] t;
    t = XW'(m) - XW'(1);
    return (x == '0) ? t[IW-1:0] : x - IW'(1);
  endfunction

  state_t           state;
  idx_t             head, tail, pos, prv, spos;
  logic [CNT_W-1:0] cnt, k;
  logic             phase;
  entry_t           carried;
  rsp_item_t        res_reg;
  entry_t           rdata;
  entry_t           mem [CAPACITY];

  logic   rd_en, wr_en;
  idx_t   rd_addr, wr_addr;
  entry_t wr_data;
  idx_t   pos_dec, prv_dec, spos_inc, head_inc, tail_inc;
  logic   pat_lt, pri_lt, move, match, last_k, deq_rd;
  logic [ST_W-1:0] take_st;

  // index helpers and comparisons
  always_comb begin
    pos_dec  = idx_dec(pos, ring);
    prv_dec  = idx_dec(prv, ring);
    spos_inc = idx_inc(spos, ring);
    head_inc = idx_inc(head, ring);
    tail_inc = idx_inc(tail, ring);
    pat_lt   = carried.patience < rdata.patience;
    pri_lt   = carried.prio < rdata.prio;
    move     = (!phase && pat_lt) || pri_lt;
    match    = rdata.id == carried.id;
    last_k   = k == (cnt - CNT_W'(1));
    deq_rd   = cmd_valid && (cnt != '0) && ((cmd.op == OP_DEQ) || (cmd.op == OP_RESORT));
  end

  // status of a request decided when it is taken
  always_comb begin
    take_st = ST_OK;
    case (cmd.op)
      OP_ENQ: begin
        if (cnt >= CNT_W'(ring)) take_st = ST_FULL;
      end
      OP_DEQ: begin
        if (cnt == '0) take_st = ST_EMPTY;
      end
      OP_RESORT: begin
        if (cnt == '0) take_st = ST_NOT_FOUND;
      end
      default: begin
        take_st = ST_OK;
      end
    endcase
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head;
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = carried;
    unique case (state)
      S_IDLE: begin
        rd_en = deq_rd;
      end
      S_START: begin
        if (pos != head) begin
          rd_en   = 1'b1;
          rd_addr = pos_dec;
        end else begin
          wr_en = 1'b1;
        end
      end
      S_BUB: begin
        wr_en = 1'b1;
        if (move) begin
          wr_data = rdata;
          if (prv != head) begin
            rd_en   = 1'b1;
            rd_addr = prv_dec;
          end
        end
      end
      S_FIN: begin
        wr_en = 1'b1;
      end
      S_SRCH: begin
        if (!match && !last_k) begin
          rd_en   = 1'b1;
          rd_addr = spos_inc;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // slot ram, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      cnt   <= '0;
      phase <= 1'b0;
    end else if (clear) begin
      head <= '0;
      tail <= '0;
      cnt  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            carried <= '{id: cmd.item_id, patience: cmd.patience, prio: cmd.priority_req};
            phase   <= 1'b0;
            res_reg <= '{item_valid: 1'b0, out_id: '0, out_patience: '0,
                         out_priority: '0, status: take_st, count: '0};
            unique case (cmd.op)
              OP_ENQ: begin
                if (cnt >= CNT_W'(ring)) begin
                  state <= S_PUT;
                end else begin
                  if (cnt == '0) begin
                    head <= '0;
                    tail <= '0;
                    pos  <= '0;
                  end else begin
                    tail <= tail_inc;
                    pos  <= tail_inc;
                  end
                  cnt   <= cnt + CNT_W'(1);
                  state <= S_START;
                end
              end
              OP_DEQ: begin
                if (cnt == '0) begin
                  state <= S_PUT;
                end else begin
                  state <= S_DEQ;
                end
              end
              OP_RESORT: begin
                if (cnt == '0) begin
                  state <= S_PUT;
                end else begin
                  spos  <= head;
                  k     <= '0;
                  state <= S_SRCH;
                end
              end
              default: begin
                state <= S_PUT;
              end
            endcase
          end
        end
        // head entry has come back from the ram
        S_DEQ: begin
          res_reg.item_valid   <= 1'b1;
          res_reg.out_id       <= rdata.id;
          res_reg.out_patience <= rdata.patience;
          res_reg.out_priority <= rdata.prio;
          if (cnt == CNT_W'(1)) begin
            head <= '0;
            tail <= '0;
          end else begin
            head <= head_inc;
          end
          cnt   <= cnt - CNT_W'(1);
          state <= S_PUT;
        end
        // walk from the head, one slot a cycle
        S_SRCH: begin
          if (match) begin
            pos   <= spos;
            state <= S_START;
          end else if (last_k) begin
            res_reg.status <= ST_NOT_FOUND;
            state          <= S_PUT;
          end else begin
            spos <= spos_inc;
            k    <= k + CNT_W'(1);
          end
        end
        S_START: begin
          if (pos == head) begin
            state <= S_PUT;
          end else begin
            prv   <= pos_dec;
            state <= S_BUB;
          end
        end
        // predecessor moves down one slot, carried entry moves up
        S_BUB: begin
          if (move) begin
            pos   <= prv;
            phase <= phase | !pat_lt;
            if (prv == head) begin
              state <= S_FIN;
            end else begin
              prv <= prv_dec;
            end
          end else begin
            state <= S_PUT;
          end
        end
        S_FIN: begin
          state <= S_PUT;
        end
        S_PUT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // handshake and result
  always_comb begin
    cmd_ready = state == S_IDLE;
    res_valid = state == S_PUT;
    res       = res_reg;
    res.count = cnt;
  end

endmodule

`default_nettype wire

// ===== design/two_key_sorted_ring_queue_unit.sv =====
// ----------------------------------------------------------------------------
// two_key_sorted_ring_queue_unit: priority queue in a sorted ring buffer
// Entries are ordered by patience, then by priority, toward the head.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake          payload
//   req       in    valid/ready        op, item_id, patience, priority_req
//   rsp       out   valid/ready        item_valid, out_id, out_patience,
//                                      out_priority, status, count
//   cfg       in    cfg_we             cfg_wdata (ring size, clears queue)
//
// Synchronous reset empties the queue; ring size 16, or CAPACITY if smaller.
// A result waits in the output register while the next request runs; the
// engine stalls in its result state only while that register is still full.
`default_nettype none

module two_key_sorted_ring_queue_unit #(
  parameter int CAPACITY = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  tksrq_req_if.sink                         req,
  tksrq_rsp_if.source                       rsp,
  input  wire logic                         cfg_we,
  input  wire logic [tksrq_pkg::RING_W-1:0] cfg_wdata
);
  import tksrq_pkg::*;

  localparam logic [RING_W-1:0] RING_RST =
    RING_W'((CAPACITY < RING_RESET) ? CAPACITY : RING_RESET);

  // register value clamped into 1 .. CAPACITY
  function automatic logic [RING_W-1:0] ring_clamp(logic [RING_W-1:0] v);
    if (v == '0) begin
      return RING_W'(1);
    end else if (int'(v) > CAPACITY) begin
      return RING_W'(CAPACITY);
    end else begin
      return v;
    end
  endfunction

  logic [RING_W-1:0] ring;
  logic              res_valid, res_ready;
  rsp_item_t         res;

  // ring size register
  always_ff @(posedge clk) begin
    if (rst) begin
      ring <= RING_RST;
    end else if (cfg_we) begin
      ring <= ring_clamp(cfg_wdata);
    end
  end

  tksrq_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (req.valid),
    .cmd_ready (req.ready),
    .cmd       (req.data),
    .ring      (ring),
    .clear     (cfg_we),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register
  assign res_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_ready) begin
      rsp.valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp.data <= res;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_two_key_sorted_ring_queue_unit.sv =====
// ----------------------------------------------------------------------------
// tb_two_key_sorted_ring_queue_unit: self-checking bench of the sorted ring queue
// A short scripted sequence, then random enqueue, dequeue and resort traffic
// over several ring sizes. Every response is compared with a software copy of
// the queue, updated on each accepted request, or with the scripted result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_two_key_sorted_ring_queue_unit;
  import tksrq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_MAX   = 16;
  localparam int SEG_ITEMS  = 192;
  localparam int END_CYCLES = 40;
  localparam int CYCLE_CAP  = 600_000;

  // op code the block leaves unused
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef enum logic [1:0] {ROW_REQ, ROW_CHECKED, ROW_RING} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [RING_W-1:0] ring;
    req_item_t         req;
    rsp_item_t         rsp;
  } script_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [RING_W-1:0] cfg_wdata;

  tksrq_req_if req_if ();
  tksrq_rsp_if rsp_if ();

  two_key_sorted_ring_queue_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the queue contents
  entry_t            ring_slot [RING_MAX];
  int unsigned       head_pos;
  int unsigned       tail_pos;
  bit                ring_empty;
  logic [RING_W-1:0] ring_reg;
  bit                filling;

  rsp_item_t   queue_responses [$];
  script_row_t script [$];
  int          ring_plan [$] = '{16, 3, 31, 1, 9, 17, 2, 16, 7};

  int send_idle_pct;
  int recv_idle_pct;
  int err_count;
  int cycle_count;

  // clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("** two_key_sorted_ring_queue_unit: FAILED **");
      $finish;
    end
  end

  function automatic int unsigned ring_len();
    if (ring_reg < 1) return 1;
    if (ring_reg > RING_MAX) return RING_MAX;
    return int'(ring_reg);
  endfunction

  function automatic int unsigned held_count(int unsigned m);
    if (ring_empty) return 0;
    return ((tail_pos + m - head_pos) % m) + 1;
  endfunction

  // patience pass, then priority pass, both toward the head
  function automatic void move_toward_head(int unsigned pos, int unsigned m);
    int unsigned prev;
    entry_t      t;
    prev = (pos + m - 1) % m;
    while (pos != head_pos && ring_slot[pos].patience < ring_slot[prev].patience) begin
      t = ring_slot[pos];
      ring_slot[pos] = ring_slot[prev];
      ring_slot[prev] = t;
      pos = prev;
      prev = (pos + m - 1) % m;
    end
    while (pos != head_pos && ring_slot[pos].prio < ring_slot[prev].prio) begin
      t = ring_slot[pos];
      ring_slot[pos] = ring_slot[prev];
      ring_slot[prev] = t;
      pos = prev;
      prev = (pos + m - 1) % m;
    end
  endfunction

  // update the shadow queue with one request and return its response
  function automatic rsp_item_t apply_queue_op(req_item_t r);
    int unsigned m;
    int unsigned n;
    int unsigned k;
    int unsigned pos;
    bit          found;
    rsp_item_t   res;
    m = ring_len();
    res = '0;
    res.status = ST_OK;
    case (r.op)
      OP_ENQ: begin
        if (held_count(m) >= m) begin
          res.status = ST_FULL;
        end else begin
          if (ring_empty) begin
            head_pos = 0;
            tail_pos = 0;
            ring_empty = 1'b0;
          end else begin
            tail_pos = (tail_pos + 1) % m;
          end
          ring_slot[tail_pos].id = r.item_id;
          ring_slot[tail_pos].patience = r.patience;
          ring_slot[tail_pos].prio = r.priority_req;
          move_toward_head(tail_pos, m);
        end
      end
      OP_DEQ: begin
        if (ring_empty) begin
          res.status = ST_EMPTY;
        end else begin
          res.item_valid = 1'b1;
          res.out_id = ring_slot[head_pos].id;
          res.out_patience = ring_slot[head_pos].patience;
          res.out_priority = ring_slot[head_pos].prio;
          if (head_pos == tail_pos) begin
            head_pos = 0;
            tail_pos = 0;
            ring_empty = 1'b1;
          end else begin
            head_pos = (head_pos + 1) % m;
          end
        end
      end
      OP_RESORT: begin
        n = held_count(m);
        pos = head_pos;
        found = 1'b0;
        // first match counted from the head
        for (k = 0; k < n && !found; k++) begin
          if (ring_slot[pos].id == r.item_id) found = 1'b1;
          else pos = (pos + 1) % m;
        end
        if (!found) begin
          res.status = ST_NOT_FOUND;
        end else begin
          ring_slot[pos].patience = r.patience;
          ring_slot[pos].prio = r.priority_req;
          move_toward_head(pos, m);
        end
      end
      default: begin
      end
    endcase
    res.count = CNT_W'(held_count(m));
    return res;
  endfunction

  // random request, biased toward filling or draining the ring in turns
  function automatic req_item_t random_request();
    req_item_t   r;
    int unsigned m;
    int unsigned n;
    int unsigned pick;
    m = ring_len();
    n = held_count(m);
    if (n == m) filling = 1'b0;
    else if (n == 0) filling = 1'b1;
    else if ($urandom_range(39) == 0) filling = !filling;
    // small ranges give duplicate ids and key ties
    r.item_id = ($urandom_range(9) < 4) ? 8'($urandom_range(7)) : 8'($urandom);
    r.patience = ($urandom_range(9) < 3) ? 8'($urandom_range(3)) : 8'($urandom);
    r.priority_req = ($urandom_range(9) < 3) ? 8'($urandom_range(3)) : 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 3) begin
      r.op = OP_SPARE;
    end else if (pick < 23) begin
      r.op = OP_RESORT;
      if (n != 0 && $urandom_range(4) != 0)
        r.item_id = ring_slot[(head_pos + $urandom_range(n - 1)) % m].id;
    end else if ($urandom_range(99) < (filling ? 70 : 30)) begin
      r.op = OP_ENQ;
    end else begin
      r.op = OP_DEQ;
    end
    return r;
  endfunction

  function automatic void flag_result(string what, rsp_item_t want, rsp_item_t got);
    err_count++;
    if (err_count <= 10)
      $display({"%0t %s: want v=%0d id=%h pat=%h pri=%h st=%0d cnt=%0d,",
                " got v=%0d id=%h pat=%h pri=%h st=%0d cnt=%0d"},
               $realtime, what,
               want.item_valid, want.out_id, want.out_patience, want.out_priority,
               want.status, want.count,
               got.item_valid, got.out_id, got.out_patience, got.out_priority,
               got.status, got.count);
  endfunction

  function automatic void add_row(row_kind_t kind, logic [RING_W-1:0] ring,
                                  logic [OP_W-1:0] op, logic [KEY_W-1:0] id,
                                  logic [KEY_W-1:0] pat, logic [KEY_W-1:0] pri,
                                  logic [ST_W-1:0] st, logic [CNT_W-1:0] cnt);
    script_row_t row;
    row = '0;
    row.kind = kind;
    row.ring = ring;
    row.req.op = op;
    row.req.item_id = id;
    row.req.patience = pat;
    row.req.priority_req = pri;
    row.rsp.status = st;
    row.rsp.count = cnt;
    script.push_back(row);
  endfunction

  // one request transaction; the shadow queue is updated on acceptance
  task automatic send_request(input req_item_t item, input bit typed,
                              input rsp_item_t typed_rsp);
    rsp_item_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= item;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    res = apply_queue_op(item);
    queue_responses.push_back(typed ? typed_rsp : res);
    @(negedge clk);
  endtask

  // ring size write once every response is back; it also empties the queue
  task automatic write_ring(input logic [RING_W-1:0] value);
    req_if.valid <= 1'b0;
    while (queue_responses.size() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    ring_reg = value;
    head_pos = 0;
    tail_pos = 0;
    ring_empty = 1'b1;
  endtask

  // response ready with random stalls
  always @(negedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // response check
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (queue_responses.size() == 0) begin
        flag_result("unexpected response", '0, rsp_if.data);
      end else begin
        if (rsp_if.data !== queue_responses[0])
          flag_result("response mismatch", queue_responses[0], rsp_if.data);
        void'(queue_responses.pop_front());
      end
    end
  end

  initial begin
    script_row_t row;
    int          k;
    int          seg;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    err_count = 0;
    cycle_count = 0;
    head_pos = 0;
    tail_pos = 0;
    ring_empty = 1'b1;
    ring_reg = RING_W'(RING_RESET);
    filling = 1'b1;
    send_idle_pct = 20;
    recv_idle_pct = 54;

    // scripted sequence: empty cases, extremes, ties, duplicate ids, full ring
    add_row(ROW_CHECKED, 0, OP_DEQ,    8'h00, 8'h00, 8'h00, ST_EMPTY, 0);
    add_row(ROW_CHECKED, 0, OP_RESORT, 8'h05, 8'h01, 8'h01, ST_NOT_FOUND, 0);
    add_row(ROW_CHECKED, 0, OP_SPARE,  8'hff, 8'hff, 8'hff, ST_OK, 0);
    add_row(ROW_CHECKED, 0, OP_ENQ,    8'hff, 8'hff, 8'hff, ST_OK, 1);
    add_row(ROW_REQ,     0, OP_ENQ,    8'h00, 8'h00, 8'h00, ST_OK, 0);
    add_row(ROW_REQ,     0, OP_ENQ,    8'h10, 8'h00, 8'hff, ST_OK, 0);
    add_row(ROW_REQ,     0, OP_ENQ,    8'h11, 8'h80, 8'h00, ST_OK, 0);
    add_row(ROW_REQ,     0, OP_ENQ,    8'h10, 8'h40, 8'h40, ST_OK, 0);
    add_row(ROW_REQ,     0, OP_RESORT, 8'h10, 8'h00, 8'h00, ST_OK, 0);
    add_row(ROW_CHECKED, 0, OP_RESORT, 8'h77, 8'h00, 8'h00, ST_NOT_FOUND, 5);
    add_row(ROW_REQ,     0, OP_RESORT, 8'hff, 8'hff, 8'h00, ST_OK, 0);
    for (k = 0; k < 5; k++)
      add_row(ROW_REQ,   0, OP_DEQ,    8'h00, 8'h00, 8'h00, ST_OK, 0);
    add_row(ROW_CHECKED, 0, OP_DEQ,    8'hff, 8'hff, 8'hff, ST_EMPTY, 0);
    add_row(ROW_RING,    5'd2, OP_ENQ, 8'h00, 8'h00, 8'h00, ST_OK, 0);
    add_row(ROW_REQ,     0, OP_ENQ,    8'ha5, 8'h5a, 8'h5a, ST_OK, 0);
    add_row(ROW_REQ,     0, OP_ENQ,    8'h5a, 8'ha5, 8'ha5, ST_OK, 0);
    add_row(ROW_CHECKED, 0, OP_ENQ,    8'h33, 8'h00, 8'h00, ST_FULL, 2);
    add_row(ROW_REQ,     0, OP_DEQ,    8'h00, 8'h00, 8'h00, ST_OK, 0);
    add_row(ROW_REQ,     0, OP_DEQ,    8'h00, 8'h00, 8'h00, ST_OK, 0);
    add_row(ROW_RING,    5'd0, OP_ENQ, 8'h00, 8'h00, 8'h00, ST_OK, 0);
    add_row(ROW_REQ,     0, OP_ENQ,    8'h3c, 8'hc3, 8'h3c, ST_OK, 0);
    add_row(ROW_CHECKED, 0, OP_ENQ,    8'hc3, 8'h00, 8'h00, ST_FULL, 1);
    add_row(ROW_REQ,     0, OP_DEQ,    8'h00, 8'h00, 8'h00, ST_OK, 0);

    // reset
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (k = 0; k < script.size(); k++) begin
      row = script[k];
      case (row.kind)
        ROW_RING:    write_ring(row.ring);
        ROW_CHECKED: send_request(row.req, 1'b1, row.rsp);
        default:     send_request(row.req, 1'b0, '0);
      endcase
    end

    // random traffic over several ring sizes and idle patterns
    for (seg = 0; seg < ring_plan.size(); seg++) begin
      if (seg == 3) begin
        send_idle_pct = 54;
        recv_idle_pct = 20;
      end else if (seg == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_ring(RING_W'(ring_plan[seg]));
      for (k = 0; k < SEG_ITEMS; k++)
        send_request(random_request(), 1'b0, '0);
    end

    // drain, then watch for stray responses
    req_if.valid <= 1'b0;
    while (queue_responses.size() != 0) @(negedge clk);
    repeat (END_CYCLES) @(negedge clk);

    if (err_count == 0) begin
      $display("** two_key_sorted_ring_queue_unit: PASSED **");
    end else begin
      $display("** two_key_sorted_ring_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
